// File: src/rdq_pkg.sv
// shared types and constants for the reversible deque command engine
package rdq_pkg;

   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int VALUE_WIDTH_MAX     = 32;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [1:0] FUNC_TEXT    = 2'd0;
   localparam logic [1:0] FUNC_COMMAND = 2'd1;
   localparam logic [1:0] FUNC_EMIT    = 2'd2;

   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_REVERSE,
      OP_DELETE,
      OP_EMIT
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [15:0] value;
      logic        is_error;
      logic        is_empty;
      logic        overflowed;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type                     op;
      logic [VALUE_WIDTH_MAX-1:0] value;
   } cmd_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

// File: src/rdq_front.sv
// front end: accepts transactions, parses array text and classifies commands
module rdq_front #(
   parameter int VALUE_WIDTH = rdq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rdq_pkg::req_type req_item,
   input  logic             q_full,
   output logic             q_push,
   output rdq_pkg::cmd_type q_cmd
);

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   seen_ff, seen_in;
   logic                   accept;
   logic                   is_digit;
   logic [VALUE_WIDTH+3:0] scaled;
   logic [3:0]             digit;

   assign busy   = q_full;
   assign accept = start & ~q_full;

   assign is_digit = (req_item.char_in >= rdq_pkg::CHAR_ZERO) &&
                     (req_item.char_in <= rdq_pkg::CHAR_NINE);
   assign digit    = 4'(req_item.char_in - rdq_pkg::CHAR_ZERO);
   // acc * 10 + digit, as two shifted copies
   assign scaled   = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} +
                     (VALUE_WIDTH + 4)'(digit);

   always_comb begin
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      q_push      = 1'b0;
      q_cmd.op    = rdq_pkg::OP_PUSH;
      q_cmd.value = rdq_pkg::VALUE_WIDTH_MAX'(acc_ff);
      if (accept) begin
         unique case (req_item.func)
            rdq_pkg::FUNC_TEXT: begin
               if (is_digit) begin
                  acc_in  = (|scaled[VALUE_WIDTH+3:VALUE_WIDTH]) ?
                            '1 : scaled[VALUE_WIDTH-1:0];
                  seen_in = 1'b1;
               end else if (req_item.char_in == rdq_pkg::CHAR_COMMA) begin
                  q_push  = 1'b1;
                  acc_in  = '0;
                  seen_in = 1'b0;
               end else if (req_item.char_in == rdq_pkg::CHAR_CLOSE) begin
                  q_push  = seen_ff;
                  acc_in  = '0;
                  seen_in = 1'b0;
               end
            end
            rdq_pkg::FUNC_COMMAND: begin
               q_push   = 1'b1;
               q_cmd.op = (req_item.char_in == rdq_pkg::CHAR_R) ?
                          rdq_pkg::OP_REVERSE : rdq_pkg::OP_DELETE;
            end
            rdq_pkg::FUNC_EMIT: begin
               // an unclosed number is dropped at end of case
               q_push   = 1'b1;
               q_cmd.op = rdq_pkg::OP_EMIT;
               acc_in   = '0;
               seen_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// File: src/rdq_queue.sv
// short command queue between the front and back ends
module rdq_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rdq_pkg::cmd_type       push_cmd,
   output logic                   full,
   input  logic                   pop,
   output rdq_pkg::queue_out_type head
);

   localparam int PW = $clog2(rdq_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(rdq_pkg::QUEUE_DEPTH + 1);

   rdq_pkg::cmd_type entry_ff [rdq_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full       = (fill_ff == CW'(rdq_pkg::QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(rdq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(rdq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/rdq_back.sv
// back end: element store, delete and reverse handling, end-of-case drain
module rdq_back #(
   parameter int DEPTH       = rdq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = rdq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rdq_pkg::queue_out_type q_head,
   output logic                   q_pop,
   output logic                   rsp_strobe,
   output rdq_pkg::rsp_type       rsp_item
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [VALUE_WIDTH-1:0] store_mem [DEPTH];

   rdq_pkg::state_type     state_ff, state_in;
   logic [IW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rev_ff, rev_in;
   logic                   err_ff, err_in;
   logic                   ovf_ff, ovf_in;
   logic [IW-1:0]          drain_ptr_ff, drain_ptr_in;
   logic [CW-1:0]          drain_left_ff, drain_left_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_data_ff, out_data_in;
   logic                   out_err_ff, out_err_in;
   logic                   out_empty_ff, out_empty_in;
   logic                   out_ovf_ff, out_ovf_in;
   logic                   out_last_ff, out_last_in;
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   logic                   wr_en;
   logic [IW-1:0]          tail;
   logic                   rd_en;

   // (base + off) mod DEPTH, base below DEPTH and off at most DEPTH
   function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [CW-1:0] off);
      logic [IW:0] sum;
      sum = (IW + 1)'(base) + (IW + 1)'(off);
      if (sum >= (IW + 1)'(DEPTH)) begin
         sum = sum - (IW + 1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   assign tail  = wrap_add(head_ff, count_ff);
   assign rd_en = (state_ff == rdq_pkg::ST_DRAIN);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      err_in        = err_ff;
      ovf_in        = ovf_ff;
      drain_ptr_in  = drain_ptr_ff;
      drain_left_in = drain_left_ff;
      out_valid_in  = 1'b0;
      out_data_in   = 1'b0;
      out_err_in    = 1'b0;
      out_empty_in  = 1'b0;
      out_ovf_in    = ovf_ff;
      out_last_in   = 1'b0;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      unique case (state_ff)
         rdq_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               unique case (q_head.cmd.op)
                  rdq_pkg::OP_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  rdq_pkg::OP_REVERSE: begin
                     if (!err_ff) begin
                        rev_in = ~rev_ff;
                     end
                  end
                  rdq_pkg::OP_DELETE: begin
                     if (!err_ff) begin
                        if (count_ff == '0) begin
                           err_in = 1'b1;
                        end else begin
                           count_in = count_ff - 1'b1;
                           if (!rev_ff) begin
                              head_in = wrap_add(head_ff, CW'(1));
                           end
                        end
                     end
                  end
                  rdq_pkg::OP_EMIT: begin
                     if (err_ff || count_ff == '0) begin
                        out_valid_in = 1'b1;
                        out_err_in   = err_ff;
                        out_empty_in = ~err_ff;
                        out_last_in  = 1'b1;
                        head_in      = '0;
                        count_in     = '0;
                        rev_in       = 1'b0;
                        err_in       = 1'b0;
                        ovf_in       = 1'b0;
                     end else begin
                        state_in      = rdq_pkg::ST_DRAIN;
                        drain_left_in = count_ff;
                        drain_ptr_in  = rev_ff ? wrap_add(head_ff, count_ff - 1'b1) : head_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         rdq_pkg::ST_DRAIN: begin
            // read issued this cycle lands in the output stage with its flags
            out_valid_in  = 1'b1;
            out_data_in   = 1'b1;
            out_last_in   = (drain_left_ff == CW'(1));
            drain_left_in = drain_left_ff - 1'b1;
            if (rev_ff) begin
               drain_ptr_in = (drain_ptr_ff == '0) ? IW'(DEPTH - 1) : drain_ptr_ff - 1'b1;
            end else begin
               drain_ptr_in = (drain_ptr_ff == IW'(DEPTH - 1)) ? '0 : drain_ptr_ff + 1'b1;
            end
            if (drain_left_ff == CW'(1)) begin
               state_in = rdq_pkg::ST_IDLE;
               head_in  = '0;
               count_in = '0;
               rev_in   = 1'b0;
               err_in   = 1'b0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = rdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rdq_pkg::ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rev_ff        <= 1'b0;
         err_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         drain_ptr_ff  <= '0;
         drain_left_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rev_ff        <= rev_in;
         err_ff        <= err_in;
         ovf_ff        <= ovf_in;
         drain_ptr_ff  <= drain_ptr_in;
         drain_left_ff <= drain_left_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_err_ff   <= out_err_in;
      out_empty_ff <= out_empty_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[tail] <= q_head.cmd.value[VALUE_WIDTH-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[drain_ptr_ff];
      end
   end

   assign rsp_strobe          = out_valid_ff;
   assign rsp_item.value      = out_data_ff ? 16'(rd_data_ff) : 16'd0;
   assign rsp_item.is_error   = out_err_ff;
   assign rsp_item.is_empty   = out_empty_ff;
   assign rsp_item.overflowed = out_ovf_ff;
   assign rsp_item.last       = out_last_ff;

endmodule

// File: src/reversible_deque_command_engine.sv
// top level of the reversible deque command engine
//
//   channel   ports                     direction   transfer
//   request   start, busy, req_item     in          start high and busy low
//   response  rsp_strobe, rsp_item      out         strobe high, one cycle
//
// one text or command byte is taken per cycle as long as the command queue has room
// end of case drains one remaining element per cycle, limited by the single
// read port of the element store; busy rises while the queue is full
// reset is synchronous and clears control state; store contents are not cleared
// the response side cannot stall; results leave the output stage as formed
module reversible_deque_command_engine #(
   parameter int DEPTH       = rdq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = rdq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rdq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output rdq_pkg::rsp_type rsp_item
);

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   rdq_pkg::cmd_type       q_cmd;
   rdq_pkg::queue_out_type q_head;

   rdq_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   rdq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   rdq_back #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
